// ===== rtl/rco_pkg.sv =====
// Shared types and constants for the rectangle/circle overlap test.
package rco_pkg;

    localparam int COORD_BITS = 16;
    localparam int SIZE_BITS  = COORD_BITS - 1;

    typedef enum logic [2:0] {
        ST_REJECT    = 3'd0,
        ST_INSIDE    = 3'd1,
        ST_CORNER    = 3'd2,
        ST_SIDE_HIT  = 3'd3,
        ST_SIDE_MISS = 3'd4
    } t_stage;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] rect_center_x;
        logic signed [COORD_BITS-1:0] rect_center_y;
        logic [SIZE_BITS-1:0]         rect_width;
        logic [SIZE_BITS-1:0]         rect_height;
        logic signed [COORD_BITS-1:0] circle_center_x;
        logic signed [COORD_BITS-1:0] circle_center_y;
        logic [SIZE_BITS-1:0]         circle_radius;
    } t_in_item;

    typedef struct packed {
        logic   overlap;
        t_stage decided_by;
    } t_out_item;

    // center offset magnitudes plus sizes
    typedef struct packed {
        logic [COORD_BITS-1:0] mx;
        logic [COORD_BITS-1:0] my;
        logic [SIZE_BITS-1:0]  w;
        logic [SIZE_BITS-1:0]  h;
        logic [SIZE_BITS-1:0]  rad;
    } t_prep;

    // values to be squared plus the early decisions
    typedef struct packed {
        logic [COORD_BITS-1:0] mx;
        logic [COORD_BITS-1:0] my;
        logic [COORD_BITS-1:0] sr;
        logic [COORD_BITS:0]   kx;
        logic [COORD_BITS:0]   ky;
        logic [SIZE_BITS-1:0]  rad;
        logic                  center_in;
        logic                  side_hit;
    } t_terms;

    typedef struct packed {
        logic [2*COORD_BITS-1:0] dx2;
        logic [2*COORD_BITS-1:0] dy2;
        logic [2*COORD_BITS-1:0] sr2;
        logic [2*COORD_BITS+1:0] kx2;
        logic [2*COORD_BITS+1:0] ky2;
        logic [2*SIZE_BITS-1:0]  rad2;
        logic                    center_in;
        logic                    side_hit;
    } t_squares;

endpackage

// ===== rtl/rect_circle_overlap_test.sv =====
// Top level of the rectangle/circle overlap test pipeline.
// One transaction enters per cycle while o_in_stall is low. Its result passes through
// five registered stages before it is presented at the output: input
// register, offset stage, term stage, squaring stage and result register, with
// the six parallel multipliers of the squaring stage setting the clock. Every
// stage holds its contents only while the stage after it is full and stalled,
// so bubbles close up and the input is stalled only when all five stages hold
// transactions and the result is being stalled.
module rect_circle_overlap_test import rco_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    logic [4:0] r_v, n_v;
    logic [4:0] en;
    t_in_item   r_in;
    t_prep      prep;
    t_terms     terms;
    t_squares   sq;

    always_comb begin
        en[4] = !r_v[4] || !i_out_stall;
        en[3] = !r_v[3] || en[4];
        en[2] = !r_v[2] || en[3];
        en[1] = !r_v[1] || en[2];
        en[0] = !r_v[0] || en[1];
        n_v[0] = en[0] ? i_in_valid : r_v[0];
        n_v[1] = en[1] ? r_v[0] : r_v[1];
        n_v[2] = en[2] ? r_v[1] : r_v[2];
        n_v[3] = en[3] ? r_v[2] : r_v[3];
        n_v[4] = en[4] ? r_v[3] : r_v[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_in <= i_in_data;
        end
    end

    rco_prep u_prep (
        .i_clk  (i_clk),
        .i_en   (en[1]),
        .i_item (r_in),
        .o_prep (prep)
    );

    rco_terms u_terms (
        .i_clk   (i_clk),
        .i_en    (en[2]),
        .i_prep  (prep),
        .o_terms (terms)
    );

    rco_square u_square (
        .i_clk   (i_clk),
        .i_en    (en[3]),
        .i_terms (terms),
        .o_sq    (sq)
    );

    rco_decide u_decide (
        .i_clk    (i_clk),
        .i_en     (en[4]),
        .i_sq     (sq),
        .o_result (o_out_data)
    );

    assign o_in_stall  = !en[0];
    assign o_out_valid = r_v[4];

endmodule

// ===== rtl/rco_prep.sv =====
// Center offset magnitudes between rectangle and circle, registered.
module rco_prep import rco_pkg::*; (
    input  logic     i_clk,
    input  logic     i_en,
    input  t_in_item i_item,
    output t_prep    o_prep
);

    t_prep r_prep, n_prep;
    logic [COORD_BITS:0] dx, dy;

    always_comb begin
        dx = {i_item.rect_center_x[COORD_BITS-1], i_item.rect_center_x}
           - {i_item.circle_center_x[COORD_BITS-1], i_item.circle_center_x};
        dy = {i_item.rect_center_y[COORD_BITS-1], i_item.rect_center_y}
           - {i_item.circle_center_y[COORD_BITS-1], i_item.circle_center_y};
        n_prep.mx  = dx[COORD_BITS] ? (~dx[COORD_BITS-1:0] + 1'b1) : dx[COORD_BITS-1:0];
        n_prep.my  = dy[COORD_BITS] ? (~dy[COORD_BITS-1:0] + 1'b1) : dy[COORD_BITS-1:0];
        n_prep.w   = i_item.rect_width;
        n_prep.h   = i_item.rect_height;
        n_prep.rad = i_item.circle_radius;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prep <= n_prep;
        end
    end

    assign o_prep = r_prep;

endmodule

// ===== rtl/rco_terms.sv =====
// Inside and side tests, plus the corner and reject terms to be squared.
module rco_terms import rco_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_prep  i_prep,
    output t_terms o_terms
);

    t_terms r_terms, n_terms;
    logic [SIZE_BITS-1:0]  big;
    logic [COORD_BITS+1:0] cx, cy, ex, ey;
    logic [COORD_BITS:0]   ex_mag, ey_mag;
    logic                  in_x, in_y;

    function automatic logic [COORD_BITS:0] mag_of(input logic [COORD_BITS+1:0] a);
        logic [COORD_BITS+1:0] m;
        m = a[COORD_BITS+1] ? (~a + 1'b1) : a;
        return m[COORD_BITS:0];
    endfunction

    always_comb begin
        big = (i_prep.w < i_prep.h) ? i_prep.h : i_prep.w;
        // doubled units: twice the offset against the full size
        cx = {1'b0, i_prep.mx, 1'b0} - {3'b0, i_prep.w};
        cy = {1'b0, i_prep.my, 1'b0} - {3'b0, i_prep.h};
        ex = {1'b0, i_prep.mx, 1'b0} - {2'b0, i_prep.rad, 1'b0};
        ey = {1'b0, i_prep.my, 1'b0} - {2'b0, i_prep.rad, 1'b0};
        ex_mag = mag_of(ex);
        ey_mag = mag_of(ey);
        in_x = {i_prep.mx, 1'b0} < {2'b0, i_prep.w};
        in_y = {i_prep.my, 1'b0} < {2'b0, i_prep.h};

        n_terms.mx        = i_prep.mx;
        n_terms.my        = i_prep.my;
        n_terms.sr        = {1'b0, big} + {1'b0, i_prep.rad};
        n_terms.kx        = mag_of(cx);
        n_terms.ky        = mag_of(cy);
        n_terms.rad       = i_prep.rad;
        n_terms.center_in = in_x && in_y;
        n_terms.side_hit  = (in_y && (ex_mag < {2'b0, i_prep.w}))
                         || (in_x && (ey_mag < {2'b0, i_prep.h}));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_terms <= n_terms;
        end
    end

    assign o_terms = r_terms;

endmodule

// ===== rtl/rco_square.sv =====
// Parallel squaring of distance, reject bound, corner offsets and radius.
module rco_square import rco_pkg::*; (
    input  logic     i_clk,
    input  logic     i_en,
    input  t_terms   i_terms,
    output t_squares o_sq
);

    t_squares r_sq, n_sq;

    always_comb begin
        n_sq.dx2       = i_terms.mx * i_terms.mx;
        n_sq.dy2       = i_terms.my * i_terms.my;
        n_sq.sr2       = i_terms.sr * i_terms.sr;
        n_sq.kx2       = i_terms.kx * i_terms.kx;
        n_sq.ky2       = i_terms.ky * i_terms.ky;
        n_sq.rad2      = i_terms.rad * i_terms.rad;
        n_sq.center_in = i_terms.center_in;
        n_sq.side_hit  = i_terms.side_hit;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule

// ===== rtl/rco_decide.sv =====
// Ordered stage decision and result register.
module rco_decide import rco_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_squares  i_sq,
    output t_out_item o_result
);

    t_out_item r_out, n_out;
    logic [2*COORD_BITS:0]   d2;
    logic [2*COORD_BITS+2:0] k2, r2x4;

    always_comb begin
        d2   = {1'b0, i_sq.dx2} + {1'b0, i_sq.dy2};
        k2   = {1'b0, i_sq.kx2} + {1'b0, i_sq.ky2};
        r2x4 = {3'b0, i_sq.rad2, 2'b00};
        if (!(d2 < {1'b0, i_sq.sr2})) begin
            n_out.overlap    = 1'b0;
            n_out.decided_by = ST_REJECT;
        end else if (i_sq.center_in) begin
            n_out.overlap    = 1'b1;
            n_out.decided_by = ST_INSIDE;
        end else if (k2 < r2x4) begin
            n_out.overlap    = 1'b1;
            n_out.decided_by = ST_CORNER;
        end else if (i_sq.side_hit) begin
            n_out.overlap    = 1'b1;
            n_out.decided_by = ST_SIDE_HIT;
        end else begin
            n_out.overlap    = 1'b0;
            n_out.decided_by = ST_SIDE_MISS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;

endmodule

// ===== rtl/rco_checker.sv =====
// Port-level assertions for the overlap test, bound to the top level.
module rco_checker import rco_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_stall,
    input logic      i_out_valid,
    input t_out_item i_out_data,
    input logic      i_out_stall
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // input backpressure only while a valid result is being stalled at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_stall |-> i_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // hit flag agrees with the deciding stage
    a_hit_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.overlap == (i_out_data.decided_by == ST_INSIDE
            || i_out_data.decided_by == ST_CORNER || i_out_data.decided_by == ST_SIDE_HIT))
        else $error("overlap flag inconsistent with stage");

    // no result right after reset
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rst_n ##1 i_rst_n |-> !i_out_valid)
        else $error("result valid right after reset");

    a_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind rect_circle_overlap_test rco_checker u_rco_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
